/* hw/rtl/meter_reading_to_lcd_text_assert.svh */
// Assertion macros used by the checker of the meter display formatter.
// Needs nothing else; included by the checker file with its bare name.
`ifndef METER_READING_TO_LCD_TEXT_ASSERT_SVH
`define METER_READING_TO_LCD_TEXT_ASSERT_SVH

// Checked on every clock edge outside reset.
`define MRL_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("meter_reading_to_lcd_text: port check failed");

// Checked on every clock edge, reset included.
`define MRL_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("meter_reading_to_lcd_text: reset check failed");

`endif

/* hw/rtl/mrl_pkg.sv */
// Types, character codes and digit helpers of the meter display formatter.
// Used by the divider, the top level and the checker; depends on nothing.
package mrl_pkg;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_VSCALE = 2'd1,
    REG_ASCALE = 2'd2
  } mrl_reg_e;

  localparam logic [15:0] VOLT_SCALE_RST = 16'd1969;
  localparam logic [15:0] AMP_SCALE_RST  = 16'd11636;

  localparam logic [13:0] MUL_CENTI  = 14'd100;
  localparam logic [13:0] MUL_MILLI  = 14'd10000;
  localparam logic [13:0] DISP_MAX   = 14'd9999;

  localparam logic [6:0] CH_SPACE = 7'h20;
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_EQ    = 7'h3D;
  localparam logic [6:0] CH_DOT   = 7'h2E;
  localparam logic [6:0] CH_U     = 7'h55;
  localparam logic [6:0] CH_I     = 7'h49;
  localparam logic [6:0] CH_V     = 7'h56;
  localparam logic [6:0] CH_A     = 7'h41;
  localparam logic [6:0] CH_M     = 7'h6D;

  typedef struct packed {
    logic cur;
    logic milli;
  } mrl_side_t;

  typedef struct packed {
    mrl_side_t   side;
    logic [15:0] scale;
    logic [29:0] prod;
  } mrl_div_in_t;

  typedef struct packed {
    mrl_side_t   side;
    logic [13:0] quo;
  } mrl_div_out_t;

  typedef struct packed {
    logic [15:0] rem;
    logic [1:0]  q;
  } mrl_step_t;

  typedef logic [9:0][13:0] mrl_wtab_t;

  localparam mrl_wtab_t W_THOU = {14'd9000, 14'd8000, 14'd7000, 14'd6000, 14'd5000,
                                  14'd4000, 14'd3000, 14'd2000, 14'd1000, 14'd0};
  localparam mrl_wtab_t W_HUND = {14'd900, 14'd800, 14'd700, 14'd600, 14'd500,
                                  14'd400, 14'd300, 14'd200, 14'd100, 14'd0};
  localparam mrl_wtab_t W_TENS = {14'd90, 14'd80, 14'd70, 14'd60, 14'd50,
                                  14'd40, 14'd30, 14'd20, 14'd10, 14'd0};

  typedef struct packed {
    logic [3:0]  digit;
    logic [13:0] rest;
  } mrl_split_t;

  // Two restoring division steps. The partial remainder stays below the divisor.
  function automatic mrl_step_t mrl_div_step(input logic [15:0] rem, input logic [1:0] bits,
                                             input logic [15:0] scale);
    mrl_step_t  r;
    logic [16:0] t;
    r.q   = '0;
    r.rem = rem;
    for (int i = 1; i >= 0; i--) begin
      t = {r.rem, bits[i]};
      if (t >= {1'b0, scale}) begin
        r.q[i] = 1'b1;
        t      = t - {1'b0, scale};
      end
      r.rem = t[15:0];
    end
    return r;
  endfunction

  // Leading decimal digit against a table of its multiples, and what is left.
  function automatic mrl_split_t mrl_split(input logic [13:0] v, input mrl_wtab_t w);
    mrl_split_t r;
    r.digit = '0;
    for (int k = 1; k < 10; k++) begin
      if (v >= w[k]) begin
        r.digit = 4'(k);
      end
    end
    r.rest = v - w[r.digit];
    return r;
  endfunction

  function automatic logic [6:0] mrl_dchar(input logic [3:0] d);
    return CH_ZERO + {3'b000, d};
  endfunction

endpackage

/* hw/rtl/mrl_div.sv */
// Pipelined restoring divider with saturation to the display maximum.
// Seven stages of two quotient bits each; uses mrl_pkg.
module mrl_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  mrl_pkg::mrl_div_in_t in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output mrl_pkg::mrl_div_out_t out_data_o
);
  import mrl_pkg::*;

  localparam int unsigned NStg = 7;

  typedef struct packed {
    mrl_side_t   side;
    logic        ovf;
    logic [15:0] scale;
    logic [15:0] rem;
    logic [13:0] low;
    logic [13:0] quo;
  } mrl_dstg_t;

  mrl_dstg_t       stg_q [NStg];
  logic [NStg-1:0] vld_q;
  logic [NStg:0]   en;

  assign en[NStg] = !out_stall_i;

  for (genvar k = 0; k < NStg; k++) begin : g_stg
    mrl_dstg_t src;
    mrl_dstg_t nxt;
    logic      src_v;
    mrl_step_t st;
    logic [13:0] qn;

    if (k == 0) begin : g_first
      logic ovf;
      assign ovf         = in_data_i.prod[29:14] >= in_data_i.scale;
      assign src.side    = in_data_i.side;
      assign src.ovf     = ovf;
      assign src.scale   = in_data_i.scale;
      assign src.rem     = ovf ? 16'd0 : in_data_i.prod[29:14];
      assign src.low     = in_data_i.prod[13:0];
      assign src.quo     = '0;
      assign src_v       = in_valid_i;
    end else begin : g_next
      assign src   = stg_q[k-1];
      assign src_v = vld_q[k-1];
    end

    always_comb begin
      st = mrl_div_step(src.rem, src.low[13:12], src.scale);
      qn = {src.quo[11:0], st.q};
      if (k == NStg - 1) begin
        if (src.ovf || qn > DISP_MAX) begin
          qn = DISP_MAX;
        end
      end
      nxt       = src;
      nxt.rem   = st.rem;
      nxt.low   = {src.low[11:0], 2'b00};
      nxt.quo   = qn;
    end

    assign en[k] = !vld_q[k] || en[k+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en[k]) begin
        vld_q[k] <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k] && src_v) begin
        stg_q[k] <= nxt;
      end
    end
  end

  assign in_stall_o       = !en[0];
  assign out_valid_o      = vld_q[NStg-1];
  assign out_data_o.side  = stg_q[NStg-1].side;
  assign out_data_o.quo   = stg_q[NStg-1].quo;

endmodule

/* hw/rtl/meter_reading_to_lcd_text.sv */
// Meter display line formatter: one 16-bit reading in, ten ASCII characters out.
// An accepted reading passes one scaling multiply, seven divider stages of two quotient bits each,
// and three decimal digit stages on its way to its result beat.
// Throughput is one reading per cycle; a stall on the output holds only the full stages.
// Reset clears all valid bits and loads the register reset values; it needs no clearing pass.
// Uses mrl_pkg and mrl_div.
module meter_reading_to_lcd_text (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [15:0] reading_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [6:0]  text_char0_o,
  output logic [6:0]  text_char1_o,
  output logic [6:0]  text_char2_o,
  output logic [6:0]  text_char3_o,
  output logic [6:0]  text_char4_o,
  output logic [6:0]  text_char5_o,
  output logic [6:0]  text_char6_o,
  output logic [6:0]  text_char7_o,
  output logic [6:0]  text_char8_o,
  output logic [6:0]  text_char9_o
);
  import mrl_pkg::*;

  typedef struct packed {
    mrl_side_t   side;
    logic [3:0]  d3;
    logic [9:0]  rest;
  } mrl_b1_t;

  typedef struct packed {
    mrl_side_t   side;
    logic [3:0]  d3;
    logic [3:0]  d2;
    logic [6:0]  rest;
  } mrl_b2_t;

  logic        cur_mode_q;
  logic [15:0] volt_scale_q;
  logic [15:0] amp_scale_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_mode_q   <= 1'b0;
      volt_scale_q <= VOLT_SCALE_RST;
      amp_scale_q  <= AMP_SCALE_RST;
    end else if (cfg_wr) begin
      unique case (mrl_reg_e'(paddr[3:2]))
        REG_MODE:   cur_mode_q   <= pwdata[0];
        REG_VSCALE: volt_scale_q <= pwdata[15:0];
        REG_ASCALE: amp_scale_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (mrl_reg_e'(paddr[3:2]))
      REG_MODE:   prdata = {31'd0, cur_mode_q};
      REG_VSCALE: prdata = {16'd0, volt_scale_q};
      REG_ASCALE: prdata = {16'd0, amp_scale_q};
      default:    prdata = '0;
    endcase
  end

  // Scaling stage.
  logic         s0_v_q;
  mrl_div_in_t  s0_q;
  mrl_div_in_t  s0_d;
  logic         s0_en;
  logic         div_stall;
  logic [13:0]  mul;

  always_comb begin
    s0_d.side.cur   = cur_mode_q;
    s0_d.side.milli = cur_mode_q && (reading_i < amp_scale_q);
    s0_d.scale      = cur_mode_q ? amp_scale_q : volt_scale_q;
    mul             = s0_d.side.milli ? MUL_MILLI : MUL_CENTI;
    s0_d.prod       = 30'(reading_i) * 30'(mul);
  end

  assign s0_en   = !s0_v_q || !div_stall;
  assign stall_o = !s0_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else if (s0_en) begin
      s0_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_en && valid_i) begin
      s0_q <= s0_d;
    end
  end

  logic         div_v;
  mrl_div_out_t div_out;
  logic         b1_en;

  mrl_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s0_v_q),
    .in_stall_o  (div_stall),
    .in_data_i   (s0_q),
    .out_valid_o (div_v),
    .out_stall_i (!b1_en),
    .out_data_o  (div_out)
  );

  // Decimal digit stages.
  logic       b1_v_q, b2_v_q, b3_v_q;
  logic       b2_en, b3_en;
  mrl_b1_t    b1_q;
  mrl_b2_t    b2_q;
  mrl_split_t sp1, sp2, sp3;

  assign b3_en = !b3_v_q || !stall_i;
  assign b2_en = !b2_v_q || b3_en;
  assign b1_en = !b1_v_q || b2_en;

  assign sp1 = mrl_split(div_out.quo, W_THOU);
  assign sp2 = mrl_split({4'd0, b1_q.rest}, W_HUND);
  assign sp3 = mrl_split({7'd0, b2_q.rest}, W_TENS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q <= 1'b0;
      b2_v_q <= 1'b0;
      b3_v_q <= 1'b0;
    end else begin
      if (b1_en) begin
        b1_v_q <= div_v;
      end
      if (b2_en) begin
        b2_v_q <= b1_v_q;
      end
      if (b3_en) begin
        b3_v_q <= b2_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (b1_en && div_v) begin
      b1_q.side <= div_out.side;
      b1_q.d3   <= sp1.digit;
      b1_q.rest <= sp1.rest[9:0];
    end
    if (b2_en && b1_v_q) begin
      b2_q.side <= b1_q.side;
      b2_q.d3   <= b1_q.d3;
      b2_q.d2   <= sp2.digit;
      b2_q.rest <= sp2.rest[6:0];
    end
  end

  logic [3:0] d1, d0;
  logic [6:0] ch0_d, ch2_d, ch3_d, ch4_d, ch6_d, ch7_d, ch8_d, ch9_d;

  always_comb begin
    d1 = sp3.digit;
    d0 = sp3.rest[3:0];
    ch0_d = b2_q.side.cur ? CH_I : CH_U;
    if (b2_q.side.milli) begin
      ch2_d = (b2_q.d3 != 4'd0) ? mrl_dchar(b2_q.d3) : CH_SPACE;
      ch3_d = (b2_q.d3 != 4'd0 || b2_q.d2 != 4'd0) ? mrl_dchar(b2_q.d2) : CH_SPACE;
      ch4_d = mrl_dchar(d1);
      ch6_d = mrl_dchar(d0);
      ch7_d = CH_ZERO;
      ch8_d = CH_M;
      ch9_d = CH_A;
    end else begin
      ch2_d = CH_SPACE;
      ch3_d = (b2_q.d3 != 4'd0) ? mrl_dchar(b2_q.d3) : CH_SPACE;
      ch4_d = mrl_dchar(b2_q.d2);
      ch6_d = mrl_dchar(d1);
      ch7_d = mrl_dchar(d0);
      ch8_d = CH_SPACE;
      ch9_d = b2_q.side.cur ? CH_A : CH_V;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b3_en && b2_v_q) begin
      text_char0_o <= ch0_d;
      text_char1_o <= CH_EQ;
      text_char2_o <= ch2_d;
      text_char3_o <= ch3_d;
      text_char4_o <= ch4_d;
      text_char5_o <= CH_DOT;
      text_char6_o <= ch6_d;
      text_char7_o <= ch7_d;
      text_char8_o <= ch8_d;
      text_char9_o <= ch9_d;
    end
  end

  assign valid_o = b3_v_q;

endmodule

/* hw/rtl/mrl_chk.sv */
// Port checker of the meter display formatter, bound to the top level below.
// Uses mrl_pkg and the macros of meter_reading_to_lcd_text_assert.svh.
`include "meter_reading_to_lcd_text_assert.svh"

module mrl_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       valid_o,
  input logic       stall_i,
  input logic [6:0] text_char0_o,
  input logic [6:0] text_char1_o,
  input logic [6:0] text_char2_o,
  input logic [6:0] text_char3_o,
  input logic [6:0] text_char4_o,
  input logic [6:0] text_char5_o,
  input logic [6:0] text_char6_o,
  input logic [6:0] text_char7_o,
  input logic [6:0] text_char8_o,
  input logic [6:0] text_char9_o
);
  import mrl_pkg::*;

  logic [69:0] line;

  assign line = {text_char0_o, text_char1_o, text_char2_o, text_char3_o, text_char4_o,
                 text_char5_o, text_char6_o, text_char7_o, text_char8_o, text_char9_o};

  `MRL_ASSERT_ALWAYS(a_rst_idle, clk_i, !rst_ni |=> !valid_o)
  `MRL_ASSERT(a_hold, clk_i, rst_ni, valid_o && stall_i |=> valid_o && $stable(line))
  `MRL_ASSERT(a_fixed, clk_i, rst_ni,
              valid_o |-> text_char1_o == CH_EQ && text_char5_o == CH_DOT)
  `MRL_ASSERT(a_milli, clk_i, rst_ni,
              valid_o && text_char8_o == CH_M |->
              text_char0_o == CH_I && text_char9_o == CH_A && text_char7_o == CH_ZERO)

endmodule

bind meter_reading_to_lcd_text mrl_chk u_mrl_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .valid_o      (valid_o),
  .stall_i      (stall_i),
  .text_char0_o (text_char0_o),
  .text_char1_o (text_char1_o),
  .text_char2_o (text_char2_o),
  .text_char3_o (text_char3_o),
  .text_char4_o (text_char4_o),
  .text_char5_o (text_char5_o),
  .text_char6_o (text_char6_o),
  .text_char7_o (text_char7_o),
  .text_char8_o (text_char8_o),
  .text_char9_o (text_char9_o)
);

/* sim/tb_meter_reading_to_lcd_text.sv */
// Self-checking testbench for the meter display line formatter meter_reading_to_lcd_text.
// A queue-fed driver, a result monitor and a built-in display predictor; needs mrl_pkg
// and the RTL of the block only.
`timescale 1ns / 100ps

module tb_meter_reading_to_lcd_text;
  import mrl_pkg::*;

  typedef logic [9:0][6:0] lcd_line_t;

  localparam int          IDLE_LIMIT  = 2000;
  localparam int          PIPE_DEPTH  = 11;
  localparam logic [31:0] DISPLAY_CAP = 32'd9999;
  localparam logic [31:0] CENTI_MUL   = 32'd100;
  localparam logic [31:0] MILLI_MUL   = 32'd10000;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [3:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        valid_i = 1'b0;
  logic        stall_o;
  logic [15:0] reading_i = '0;
  logic        valid_o;
  logic        stall_i = 1'b0;
  logic [6:0]  text_char0_o, text_char1_o, text_char2_o, text_char3_o, text_char4_o;
  logic [6:0]  text_char5_o, text_char6_o, text_char7_o, text_char8_o, text_char9_o;

  logic        cfg_mode   = 1'b0;
  logic [15:0] cfg_vscale = VOLT_SCALE_RST;
  logic [15:0] cfg_ascale = AMP_SCALE_RST;

  logic [15:0] feed_q[$];
  lcd_line_t   lcd_q[$];
  logic        in_beat = 1'b0;
  int          send_idle_pct = 16;
  int          recv_idle_pct = 51;
  int          errors = 0;
  int          quiet_cycles = 0;

  meter_reading_to_lcd_text DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .valid_i      (valid_i),
    .stall_o      (stall_o),
    .reading_i    (reading_i),
    .valid_o      (valid_o),
    .stall_i      (stall_i),
    .text_char0_o (text_char0_o),
    .text_char1_o (text_char1_o),
    .text_char2_o (text_char2_o),
    .text_char3_o (text_char3_o),
    .text_char4_o (text_char4_o),
    .text_char5_o (text_char5_o),
    .text_char6_o (text_char6_o),
    .text_char7_o (text_char7_o),
    .text_char8_o (text_char8_o),
    .text_char9_o (text_char9_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [31:0] scaled_reading(input logic [15:0] rd, input logic [31:0] mul,
                                                 input logic [15:0] sc);
    logic [31:0] q;
    if (sc == 16'd0) begin
      return DISPLAY_CAP;
    end
    q = (32'(rd) * mul) / 32'(sc);
    return (q > DISPLAY_CAP) ? DISPLAY_CAP : q;
  endfunction

  function automatic logic [6:0] digit_ch(input logic [31:0] v);
    return CH_ZERO + 7'(v % 32'd10);
  endfunction

  function automatic lcd_line_t format_reading(input logic [15:0] rd);
    lcd_line_t   t;
    logic [31:0] q;
    logic        milli;
    milli = cfg_mode && (rd < cfg_ascale);
    if (milli) begin
      q = scaled_reading(rd, MILLI_MUL, cfg_ascale);
    end else if (cfg_mode) begin
      q = scaled_reading(rd, CENTI_MUL, cfg_ascale);
    end else begin
      q = scaled_reading(rd, CENTI_MUL, cfg_vscale);
    end
    t[0] = cfg_mode ? CH_I : CH_U;
    t[1] = CH_EQ;
    t[5] = CH_DOT;
    t[9] = cfg_mode ? CH_A : CH_V;
    if (milli) begin
      t[2] = (q >= 32'd1000) ? digit_ch(q / 32'd1000) : CH_SPACE;
      t[3] = (q >= 32'd100) ? digit_ch(q / 32'd100) : CH_SPACE;
      t[4] = digit_ch(q / 32'd10);
      t[6] = digit_ch(q);
      t[7] = CH_ZERO;
      t[8] = CH_M;
    end else begin
      t[2] = CH_SPACE;
      t[3] = (q >= 32'd1000) ? digit_ch(q / 32'd1000) : CH_SPACE;
      t[4] = digit_ch(q / 32'd100);
      t[6] = digit_ch(q / 32'd10);
      t[7] = digit_ch(q);
      t[8] = CH_SPACE;
    end
    return t;
  endfunction

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      valid_i <= 1'b0;
    end else if (!valid_i || in_beat) begin
      if (feed_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        valid_i   <= 1'b1;
        reading_i <= feed_q.pop_front();
      end else begin
        valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin : monitor
    lcd_line_t got;
    lcd_line_t want;
    in_beat <= rst_ni && valid_i && !stall_o;
    if (rst_ni && valid_o && !stall_i) begin
      got = {text_char9_o, text_char8_o, text_char7_o, text_char6_o, text_char5_o,
             text_char4_o, text_char3_o, text_char2_o, text_char1_o, text_char0_o};
      if (lcd_q.size() == 0) begin
        $error("Result beat arrived with no reading pending.");
        errors++;
      end else begin
        want = lcd_q.pop_front();
        for (int k = 0; k < 10; k++) begin
          if (got[k] !== want[k]) begin
            $error("text_char%0d: expected %h, got %h", k, want[k], got[k]);
            errors++;
          end
        end
      end
    end
    if (rst_ni && valid_i && !stall_o) begin
      lcd_q.push_back(format_reading(reading_i));
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (valid_i && !stall_o) || (valid_o && !stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic drain_all();
    while (feed_q.size() != 0 || valid_i || lcd_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic reg_write(input mrl_reg_e idx, input logic [15:0] val);
    logic [31:0] mask;
    logic [31:0] word;
    mask = (idx == REG_MODE) ? 32'h1 : 32'hFFFF;
    word = ($urandom() & ~mask) | (32'(val) & mask);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MODE:   cfg_mode = word[0];
      REG_VSCALE: cfg_vscale = word[15:0];
      default:    cfg_ascale = word[15:0];
    endcase
  endtask

  task automatic set_config(input logic mode, input logic [15:0] vs, input logic [15:0] as);
    drain_all();
    reg_write(REG_MODE, {15'd0, mode});
    reg_write(REG_VSCALE, vs);
    reg_write(REG_ASCALE, as);
  endtask

  function automatic logic [15:0] pick_scale(input logic [15:0] rst_val);
    case ($urandom_range(7))
      0:       return 16'd1;
      1:       return 16'hFFFF;
      2:       return rst_val;
      3:       return 16'($urandom_range(1, 255));
      4:       return 16'd0;
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  function automatic logic [15:0] pick_reading();
    int thr;
    int r;
    case ($urandom_range(4))
      0: return 16'($urandom());
      1: begin
        if (cfg_ascale == 16'd0) begin
          return 16'($urandom());
        end
        return 16'($urandom_range(0, int'(cfg_ascale) - 1));
      end
      2: begin
        thr = cfg_mode ? int'(cfg_ascale) : int'(cfg_vscale);
        r   = thr + int'($urandom_range(4)) - 2;
        if (r < 0) begin
          r = 0;
        end else if (r > 65535) begin
          r = 65535;
        end
        return 16'(r);
      end
      3:       return 16'($urandom_range(255));
      default: return 16'(65535 - $urandom_range(255));
    endcase
  endfunction

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset register values: voltage mode at the default scale.
    feed_q.push_back(16'd0);
    feed_q.push_back(16'd1);
    feed_q.push_back(16'd1968);
    feed_q.push_back(16'd1969);
    feed_q.push_back(16'hFFFF);
    // Current mode around the milliamp threshold.
    set_config(1'b1, 16'd1, AMP_SCALE_RST);
    feed_q.push_back(16'd0);
    feed_q.push_back(16'd1);
    feed_q.push_back(16'd11635);
    feed_q.push_back(16'd11636);
    feed_q.push_back(16'hFFFF);
    // Voltage saturating at the top of the display.
    set_config(1'b0, 16'd1, 16'd1);
    feed_q.push_back(16'd99);
    feed_q.push_back(16'd100);
    feed_q.push_back(16'hFFFF);
    // Ampere range saturating, and the largest milliamp value.
    set_config(1'b1, 16'hFFFF, 16'd1);
    feed_q.push_back(16'd0);
    feed_q.push_back(16'hFFFF);
    set_config(1'b1, 16'hFFFF, 16'hFFFF);
    feed_q.push_back(16'hFFFE);
    feed_q.push_back(16'hFFFF);
    // Zero scales in both modes.
    set_config(1'b0, 16'd0, 16'd0);
    feed_q.push_back(16'd0);
    feed_q.push_back(16'd12345);
    set_config(1'b1, 16'd0, 16'd0);
    feed_q.push_back(16'd0);
    feed_q.push_back(16'hFFFF);

    for (int p = 0; p < 12; p++) begin
      set_config(1'($urandom_range(1)), pick_scale(VOLT_SCALE_RST), pick_scale(AMP_SCALE_RST));
      if (p < 4) begin
        send_idle_pct = 16;
        recv_idle_pct = 51;
      end else if (p < 8) begin
        send_idle_pct = 51;
        recv_idle_pct = 16;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // Two bursts per setting, with the sender held until every result is back.
      for (int b = 0; b < 2; b++) begin
        for (int i = 0; i < 44; i++) begin
          feed_q.push_back(pick_reading());
        end
        drain_all();
      end
    end

    drain_all();
    repeat (2 * PIPE_DEPTH) @(posedge clk_i);
    if (errors == 0 && lcd_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
